/* src/patp_pkg.sv */
package patp_pkg;

  localparam int unsigned EXTENDED_BIT_DEFAULT = 4;

  localparam int unsigned DATA_W   = 8;
  localparam int unsigned LENGTH_W = 16;
  localparam int unsigned ROLE_W   = 3;

  // Output stream packing.
  localparam int unsigned M_TDATA_W = 56;
  localparam int unsigned M_TUSER_W = 5;

  // Parser phase; the byte role of a byte equals the phase it arrives in.
  typedef enum logic [ROLE_W-1:0] {
    PH_FLAGS  = 3'd0,
    PH_TYPE   = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_VALUE  = 3'd4
  } phase_e;

  localparam logic [ROLE_W-1:0] ROLE_FLAGS  = 3'd0;
  localparam logic [ROLE_W-1:0] ROLE_TYPE   = 3'd1;
  localparam logic [ROLE_W-1:0] ROLE_LEN_HI = 3'd2;
  localparam logic [ROLE_W-1:0] ROLE_LEN_LO = 3'd3;
  localparam logic [ROLE_W-1:0] ROLE_VALUE  = 3'd4;

  typedef struct packed {
    logic [ROLE_W-1:0]   byte_role;
    logic [DATA_W-1:0]   data_out;
    logic [DATA_W-1:0]   attr_flags;
    logic [DATA_W-1:0]   attr_type;
    logic [LENGTH_W-1:0] value_length;
    logic [LENGTH_W-1:0] value_offset;
    logic                attribute_end;
    logic                frame_end;
    logic                frame_error;
  } patp_result_t;

endpackage

/* src/path_attribute_tlv_parser_core.sv */
// Path attribute parser for the attribute section of a route update.
// The slave stream carries one section byte per transfer, with tlast on the
// final byte of the section. Every byte comes out on the master stream as one
// transfer tagged with its role (flags, type, length high/only, length low,
// value), the current attribute's flags, type and declared length, and the
// offset of a value byte within the value. tuser marks the byte that completes
// an attribute and, on the tlast byte, a section that ends inside an attribute.
// The flag bit that selects a two-byte length is set by ExtendedBit.
// Each byte passes an input register and then a result register, with a single
// parse step between the two; one byte per cycle is sustained while the
// receiver takes every result. Reset empties both registers and returns the
// parser to expecting a flags byte; every section end returns it there too.
// When the receiver stalls, the result register holds its transfer and the
// input register still takes one more byte; after that tready falls until the
// result is taken.
module path_attribute_tlv_parser_core #(
  parameter int unsigned ExtendedBit = patp_pkg::EXTENDED_BIT_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [7:0]                     s_axis_tdata_i,   // data_byte[7:0]
  input  logic                           s_axis_tlast_i,   // last_byte
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // data_out[7:0], attr_flags[15:8], attr_type[23:16], value_length[39:24],
  // value_offset[55:40]
  output logic [patp_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  // byte_role[2:0], attribute_end[3], frame_error[4]
  output logic [patp_pkg::M_TUSER_W-1:0] m_axis_tuser_o,
  output logic                           m_axis_tlast_o    // frame_end
);
  import patp_pkg::*;

  logic         in_valid_q;
  logic [7:0]   in_data_q;
  logic         in_last_q;
  logic         out_valid_q;
  patp_result_t out_q;
  patp_result_t step_res;
  logic         out_free;
  logic         advance;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_data_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  patp_step #(
    .ExtendedBit(ExtendedBit)
  ) u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(advance),
    .data_i   (in_data_q),
    .last_i   (in_last_q),
    .result_o (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= step_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.value_offset, out_q.value_length, out_q.attr_type,
                            out_q.attr_flags, out_q.data_out};
  assign m_axis_tuser_o  = {out_q.frame_error, out_q.attribute_end, out_q.byte_role};
  assign m_axis_tlast_o  = out_q.frame_end;

  a_error_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[4] |-> m_axis_tlast_o)
    else $error("frame error reported away from the section end");

  a_end_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[3] |->
      (m_axis_tuser_o[2:0] == ROLE_LEN_HI) || (m_axis_tuser_o[2:0] == ROLE_LEN_LO) ||
      (m_axis_tuser_o[2:0] == ROLE_VALUE))
    else $error("attribute end on a header byte");

  a_offset_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o[2:0] != ROLE_VALUE) |-> m_axis_tdata_o[55:40] == '0)
    else $error("value offset set on a non-value byte");

  a_flags_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o[2:0] == ROLE_FLAGS) |->
      (m_axis_tdata_o[15:8] == m_axis_tdata_o[7:0]) && (m_axis_tdata_o[23:16] == '0))
    else $error("flags byte not latched as attribute flags");

endmodule

/* src/patp_step.sv */
module patp_step #(
  parameter int unsigned ExtendedBit = patp_pkg::EXTENDED_BIT_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   advance_i,
  input  logic [7:0]             data_i,
  input  logic                   last_i,
  output patp_pkg::patp_result_t result_o
);
  import patp_pkg::*;

  localparam logic [2:0] ExtIdx = 3'(ExtendedBit);

  phase_e              phase_q, phase_d;
  logic [DATA_W-1:0]   flags_q, flags_d;
  logic [DATA_W-1:0]   type_q, type_d;
  logic [LENGTH_W-1:0] len_q, len_d;
  logic [LENGTH_W-1:0] rem_q, rem_d;
  logic [LENGTH_W-1:0] pos_q, pos_d;
  logic                extended;

  assign extended = flags_q[ExtIdx];

  // Next state of the attribute parser, before the section end forces the flags phase.
  always_comb begin
    phase_d = phase_q;
    flags_d = flags_q;
    type_d  = type_q;
    len_d   = len_q;
    rem_d   = rem_q;
    pos_d   = pos_q;
    case (phase_q)
      PH_TYPE: begin
        type_d  = data_i;
        phase_d = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        if (extended) begin
          len_d   = {data_i, 8'h00};
          phase_d = PH_LEN_LO;
        end else begin
          len_d   = {8'h00, data_i};
          rem_d   = len_d;
          pos_d   = '0;
          phase_d = (len_d == '0) ? PH_FLAGS : PH_VALUE;
        end
      end
      PH_LEN_LO: begin
        len_d   = {len_q[15:8], data_i};
        rem_d   = len_d;
        pos_d   = '0;
        phase_d = (len_d == '0) ? PH_FLAGS : PH_VALUE;
      end
      PH_VALUE: begin
        pos_d = pos_q + 16'd1;
        rem_d = rem_q - 16'd1;
        if (rem_q == 16'd1) begin
          phase_d = PH_FLAGS;
        end
      end
      default: begin
        flags_d = data_i;
        type_d  = '0;
        len_d   = '0;
        rem_d   = '0;
        pos_d   = '0;
        phase_d = PH_TYPE;
      end
    endcase
  end

  always_comb begin
    result_o.byte_role     = ROLE_FLAGS;
    result_o.value_offset  = '0;
    result_o.attribute_end = 1'b0;
    case (phase_q)
      PH_TYPE: begin
        result_o.byte_role = ROLE_TYPE;
      end
      PH_LEN_HI: begin
        result_o.byte_role     = ROLE_LEN_HI;
        result_o.attribute_end = !extended && (data_i == '0);
      end
      PH_LEN_LO: begin
        result_o.byte_role     = ROLE_LEN_LO;
        result_o.attribute_end = (len_d == '0);
      end
      PH_VALUE: begin
        result_o.byte_role     = ROLE_VALUE;
        result_o.value_offset  = pos_q;
        result_o.attribute_end = (rem_q == 16'd1);
      end
      default: begin
        result_o.byte_role = ROLE_FLAGS;
      end
    endcase
    result_o.data_out     = data_i;
    result_o.attr_flags   = flags_d;
    result_o.attr_type    = type_d;
    result_o.value_length = len_d;
    result_o.frame_end    = last_i;
    result_o.frame_error  = last_i && (phase_d != PH_FLAGS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FLAGS;
      flags_q <= '0;
      type_q  <= '0;
      len_q   <= '0;
      rem_q   <= '0;
      pos_q   <= '0;
    end else if (advance_i) begin
      phase_q <= last_i ? PH_FLAGS : phase_d;
      flags_q <= flags_d;
      type_q  <= type_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
      pos_q   <= pos_d;
    end
  end

endmodule
